>>> src/hsvrgb_pkg.sv
// Shared constants and types of the HSV to RGB percent converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int HUE_W   = 9;
   localparam int PCT_W   = 7;
   localparam int LEVEL_W = 8;
   localparam int REM_W   = 6;    // degrees within one sector, 0..59
   localparam int SQ_W    = 14;   // up to PCT_SQ
   localparam int PROD_W  = 20;   // value times a term up to PCT_SQ

   localparam logic [HUE_W-1:0]   HUE_MAX    = 9'd360;
   localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
   localparam logic [HUE_W-1:0]   SECTOR_DEG = 9'd60;
   localparam logic [SQ_W-1:0]    PCT_SQ     = 14'd10000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;

   // Reciprocals: floor(x / d) == (x * M) >> K over the ranges used here.
   localparam logic [7:0]  RECIP3_M     = 8'd171;      // x <= 295, K = 9
   localparam int          RECIP3_K     = 9;
   localparam logic [13:0] RECIP100_M   = 14'd10486;   // x <= 25500, K = 20
   localparam int          RECIP100_K   = 20;
   localparam logic [18:0] RECIP10K_M   = 19'd429497;  // x <= 10^6, K = 32
   localparam int          RECIP10K_K   = 32;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

>>> src/hsv_to_rgb_percent.sv
// Top level: five-stage pipelined HSV (degrees, percent) to 8-bit RGB converter.
// A word accepted by start passes through the registers s1, s2, s3, s4 and rsp
//   and then appears on rsp_* with rsp_valid high: five register stages in all.
// Throughput: one word per cycle; busy is always low, each stage holds one word.
// Reciprocal multipliers stand in for division in stages one, three, four and five.
// Reset (synchronous, active high) clears every stage valid bit; data regs are not reset.
`timescale 1ns / 1ps

module hsv_to_rgb_percent (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [hsvrgb_pkg::HUE_W-1:0]     req_hue_deg,
   input  logic [hsvrgb_pkg::PCT_W-1:0]     req_sat_pct,
   input  logic [hsvrgb_pkg::PCT_W-1:0]     req_val_pct,
   output logic                             rsp_valid,
   output logic [hsvrgb_pkg::LEVEL_W-1:0]   rsp_red,
   output logic [hsvrgb_pkg::LEVEL_W-1:0]   rsp_green,
   output logic [hsvrgb_pkg::LEVEL_W-1:0]   rsp_blue
);

   localparam int HUE_W   = hsvrgb_pkg::HUE_W;
   localparam int PCT_W   = hsvrgb_pkg::PCT_W;
   localparam int LEVEL_W = hsvrgb_pkg::LEVEL_W;
   localparam int REM_W   = hsvrgb_pkg::REM_W;
   localparam int SQ_W    = hsvrgb_pkg::SQ_W;
   localparam int PROD_W  = hsvrgb_pkg::PROD_W;

   // The receiver never stalls, so every stage advances each cycle.
   assign busy = 1'b0;

   logic req_accept;
   assign req_accept = start && !busy;

   // ---------------------------------------------------------------------
   // Stage 1: clamp inputs, find the sector and the percent fraction in it.
   // ---------------------------------------------------------------------
   logic [HUE_W-1:0]       hue_clamp;
   logic [PCT_W-1:0]       sat_clamp;
   logic [PCT_W-1:0]       val_clamp;
   hsvrgb_pkg::sector_type sector_in;
   logic [HUE_W-1:0]       sector_base;
   logic [REM_W-1:0]       rem_deg;
   logic [8:0]             rem_x5;
   logic [15:0]            frac_prod;
   logic [PCT_W-1:0]       frac_in;

   always_comb begin
      hue_clamp = (req_hue_deg > hsvrgb_pkg::HUE_MAX) ? hsvrgb_pkg::HUE_MAX : req_hue_deg;
      sat_clamp = (req_sat_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : req_sat_pct;
      val_clamp = (req_val_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : req_val_pct;

      // Full circle folds back onto the first sector with zero fraction.
      if (hue_clamp >= hsvrgb_pkg::HUE_MAX) begin
         sector_in   = hsvrgb_pkg::SECTOR_RED_YELLOW;
         sector_base = hsvrgb_pkg::HUE_MAX;
      end else if (hue_clamp >= HUE_W'(5 * hsvrgb_pkg::SECTOR_DEG)) begin
         sector_in   = hsvrgb_pkg::SECTOR_MAGENTA_RED;
         sector_base = HUE_W'(5 * hsvrgb_pkg::SECTOR_DEG);
      end else if (hue_clamp >= HUE_W'(4 * hsvrgb_pkg::SECTOR_DEG)) begin
         sector_in   = hsvrgb_pkg::SECTOR_BLUE_MAGENTA;
         sector_base = HUE_W'(4 * hsvrgb_pkg::SECTOR_DEG);
      end else if (hue_clamp >= HUE_W'(3 * hsvrgb_pkg::SECTOR_DEG)) begin
         sector_in   = hsvrgb_pkg::SECTOR_CYAN_BLUE;
         sector_base = HUE_W'(3 * hsvrgb_pkg::SECTOR_DEG);
      end else if (hue_clamp >= HUE_W'(2 * hsvrgb_pkg::SECTOR_DEG)) begin
         sector_in   = hsvrgb_pkg::SECTOR_GREEN_CYAN;
         sector_base = HUE_W'(2 * hsvrgb_pkg::SECTOR_DEG);
      end else if (hue_clamp >= hsvrgb_pkg::SECTOR_DEG) begin
         sector_in   = hsvrgb_pkg::SECTOR_YELLOW_GREEN;
         sector_base = hsvrgb_pkg::SECTOR_DEG;
      end else begin
         sector_in   = hsvrgb_pkg::SECTOR_RED_YELLOW;
         sector_base = '0;
      end

      // frac = floor(rem * 100 / 60) = floor(rem * 5 / 3)
      rem_deg   = REM_W'(hue_clamp - sector_base);
      rem_x5    = {1'b0, rem_deg, 2'b00} + {3'b000, rem_deg};
      frac_prod = {7'd0, rem_x5} * {8'd0, hsvrgb_pkg::RECIP3_M};
      frac_in   = frac_prod[hsvrgb_pkg::RECIP3_K +: PCT_W];
   end

   logic                   s1_valid_ff;
   hsvrgb_pkg::sector_type s1_sector_ff;
   logic [PCT_W-1:0]       s1_frac_ff;
   logic [PCT_W-1:0]       s1_sat_ff;
   logic [PCT_W-1:0]       s1_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      s1_sector_ff <= sector_in;
      s1_frac_ff   <= frac_in;
      s1_sat_ff    <= sat_clamp;
      s1_val_ff    <= val_clamp;
   end

   // ---------------------------------------------------------------------
   // Stage 2: saturation products. Zero saturation needs no special path:
   // every level below then works out to the value itself.
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0] sat_frac;
   logic [SQ_W-1:0] sat_cofrac;
   logic [SQ_W-1:0] fall_term_in;
   logic [SQ_W-1:0] rise_term_in;
   logic [SQ_W-1:0] low_num_in;

   always_comb begin
      sat_frac     = SQ_W'(s1_sat_ff) * SQ_W'(s1_frac_ff);
      sat_cofrac   = SQ_W'(s1_sat_ff) * SQ_W'(hsvrgb_pkg::PCT_MAX - s1_frac_ff);
      fall_term_in = hsvrgb_pkg::PCT_SQ - sat_frac;
      rise_term_in = hsvrgb_pkg::PCT_SQ - sat_cofrac;
      low_num_in   = SQ_W'(s1_val_ff) * SQ_W'(hsvrgb_pkg::PCT_MAX - s1_sat_ff);
   end

   logic                   s2_valid_ff;
   hsvrgb_pkg::sector_type s2_sector_ff;
   logic [PCT_W-1:0]       s2_val_ff;
   logic [SQ_W-1:0]        s2_fall_term_ff;
   logic [SQ_W-1:0]        s2_rise_term_ff;
   logic [SQ_W-1:0]        s2_low_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sector_ff    <= s1_sector_ff;
      s2_val_ff       <= s1_val_ff;
      s2_fall_term_ff <= fall_term_in;
      s2_rise_term_ff <= rise_term_in;
      s2_low_num_ff   <= low_num_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale the falling and rising terms by value; finish low / 100.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] fall_num_in;
   logic [PROD_W-1:0] rise_num_in;
   logic [27:0]       low_prod;
   logic [PCT_W-1:0]  low_in;

   always_comb begin
      fall_num_in = PROD_W'(s2_val_ff) * PROD_W'(s2_fall_term_ff);
      rise_num_in = PROD_W'(s2_val_ff) * PROD_W'(s2_rise_term_ff);
      low_prod    = {14'd0, s2_low_num_ff} * {14'd0, hsvrgb_pkg::RECIP100_M};
      low_in      = low_prod[hsvrgb_pkg::RECIP100_K +: PCT_W];
   end

   logic                   s3_valid_ff;
   hsvrgb_pkg::sector_type s3_sector_ff;
   logic [PCT_W-1:0]       s3_val_ff;
   logic [PCT_W-1:0]       s3_low_ff;
   logic [PROD_W-1:0]      s3_fall_num_ff;
   logic [PROD_W-1:0]      s3_rise_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_sector_ff   <= s2_sector_ff;
      s3_val_ff      <= s2_val_ff;
      s3_low_ff      <= low_in;
      s3_fall_num_ff <= fall_num_in;
      s3_rise_num_ff <= rise_num_in;
   end

   // ---------------------------------------------------------------------
   // Stage 4: divide the falling and rising numerators by 10000.
   // ---------------------------------------------------------------------
   logic [38:0]      fall_prod;
   logic [38:0]      rise_prod;
   logic [PCT_W-1:0] fall_in;
   logic [PCT_W-1:0] rise_in;

   always_comb begin
      fall_prod = {19'd0, s3_fall_num_ff} * {20'd0, hsvrgb_pkg::RECIP10K_M};
      rise_prod = {19'd0, s3_rise_num_ff} * {20'd0, hsvrgb_pkg::RECIP10K_M};
      fall_in   = fall_prod[hsvrgb_pkg::RECIP10K_K +: PCT_W];
      rise_in   = rise_prod[hsvrgb_pkg::RECIP10K_K +: PCT_W];
   end

   logic                   s4_valid_ff;
   hsvrgb_pkg::sector_type s4_sector_ff;
   logic [PCT_W-1:0]       s4_val_ff;
   logic [PCT_W-1:0]       s4_low_ff;
   logic [PCT_W-1:0]       s4_fall_ff;
   logic [PCT_W-1:0]       s4_rise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_sector_ff <= s3_sector_ff;
      s4_val_ff    <= s3_val_ff;
      s4_low_ff    <= s3_low_ff;
      s4_fall_ff   <= fall_in;
      s4_rise_ff   <= rise_in;
   end

   // ---------------------------------------------------------------------
   // Stage 5: pick levels per sector, then scale percent to 0..255.
   // ---------------------------------------------------------------------
   logic [PCT_W-1:0]   red_pct;
   logic [PCT_W-1:0]   green_pct;
   logic [PCT_W-1:0]   blue_pct;
   logic [LEVEL_W-1:0] red_in;
   logic [LEVEL_W-1:0] green_in;
   logic [LEVEL_W-1:0] blue_in;

   function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] pct);
      logic [14:0] scaled;
      logic [28:0] prod;
      // pct * 255 as a shift and subtract, then / 100 by reciprocal
      scaled = {pct, 8'd0} - {8'd0, pct};
      prod   = {14'd0, scaled} * {15'd0, hsvrgb_pkg::RECIP100_M};
      return prod[hsvrgb_pkg::RECIP100_K +: LEVEL_W];
   endfunction

   always_comb begin
      case (s4_sector_ff)
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            red_pct = s4_fall_ff; green_pct = s4_val_ff;  blue_pct = s4_low_ff;
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            red_pct = s4_low_ff;  green_pct = s4_val_ff;  blue_pct = s4_rise_ff;
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            red_pct = s4_low_ff;  green_pct = s4_fall_ff; blue_pct = s4_val_ff;
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            red_pct = s4_rise_ff; green_pct = s4_low_ff;  blue_pct = s4_val_ff;
         end
         hsvrgb_pkg::SECTOR_MAGENTA_RED: begin
            red_pct = s4_val_ff;  green_pct = s4_low_ff;  blue_pct = s4_fall_ff;
         end
         default: begin
            red_pct = s4_val_ff;  green_pct = s4_rise_ff; blue_pct = s4_low_ff;
         end
      endcase
      red_in   = pct_to_level(red_pct);
      green_in = pct_to_level(green_pct);
      blue_in  = pct_to_level(blue_pct);
   end

   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_red_ff;
   logic [LEVEL_W-1:0] rsp_green_ff;
   logic [LEVEL_W-1:0] rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s4_valid_ff;
      end
      rsp_red_ff   <= red_in;
      rsp_green_ff <= green_in;
      rsp_blue_ff  <= blue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

`ifndef SYNTHESIS
   // The response strobe matches the accept strobe delayed through the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
       && !$past(reset, 4) && !$past(reset, 5))
      |-> (rsp_valid == $past(req_accept, 5)))
      else $error("response strobe does not follow request by five cycles");

   // The fraction within a sector stays below one whole sector.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_frac_ff < hsvrgb_pkg::PCT_MAX))
      else $error("sector fraction out of range");

   // Every derived level is bounded by the value level it came from.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_low_ff <= s4_val_ff && s4_fall_ff <= s4_val_ff
                       && s4_rise_ff <= s4_val_ff))
      else $error("derived level exceeds value level");

   // A full-scale value with no saturation yields full white.
   a_white: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_val_ff == hsvrgb_pkg::PCT_MAX && s4_low_ff == s4_val_ff)
      |=> (rsp_red == hsvrgb_pkg::LEVEL_MAX && rsp_green == hsvrgb_pkg::LEVEL_MAX
           && rsp_blue == hsvrgb_pkg::LEVEL_MAX))
      else $error("full-scale grey did not produce white");
`endif

endmodule
